### sv/tbpc_pkg.sv
// ---------------------------------------------------------------------------
// tbpc_pkg: shared types and constants of the tipping-bucket pulse counter
// Word layouts, operation codes, register indexes and sizes of the counter
// bank used by the core and its storage.
// ---------------------------------------------------------------------------
package tbpc_pkg;

   // Size of the counter bank.
   localparam int CHANNELS = 8;
   // A read-out reports at most eight channels, the most a 3-bit channel field carries.
   localparam int REPORT_MAX = 8;
   localparam int REPORT_COUNT = (CHANNELS < REPORT_MAX) ? CHANNELS : REPORT_MAX;
   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int TOTAL_W = 48;
   localparam int VOLUME_W = 32;
   localparam int WINDOW_W = 16;
   localparam int CHAN_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(65536);
   localparam logic [WINDOW_W-1:0] LOCKOUT_RESET = WINDOW_W'(100);

   // Operation codes.
   localparam logic [1:0] OP_TIP = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_VOLUME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LOCKOUT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CHAN_W-1:0] channel;
      logic              clear_after;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TIP,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

endpackage

### sv/tbpc_ram.sv
// ---------------------------------------------------------------------------
// tbpc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ---------------------------------------------------------------------------
module tbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tipping_bucket_pulse_counter_core.sv
// ---------------------------------------------------------------------------
// tipping_bucket_pulse_counter_core: bank of saturating tip counters
// Counts debounced bucket tips per channel, clears lockout flags on a
// millisecond window and reports all totals in channel order on request.
// ---------------------------------------------------------------------------
//
//   channel  direction  word                         handshake
//   req_     in         tbpc_pkg::req_type           req_valid / req_ready
//   rsp_     out        tbpc_pkg::rsp_type           rsp_valid / rsp_ready
//   csr_     in         index + 32-bit write data    csr_we, no wait
//
// A tick, a clear or a tip on a locked or absent channel is done when the
// word is accepted.  A tip on an open channel reads its total from the
// totals RAM and, in ST_TIP, writes back the saturated sum.  A read accepts
// the word, sets up the RAM address in ST_RD_ADDR and then, in ST_RD_DATA,
// loads the totals in channel order into the output register; the one read
// port of the RAM serializes them.  The core takes one input word at a
// time.  Reset needs no sweep of the RAM: per-entry valid bits make every
// total read as zero until it is written again.  A stalled output holds the
// read-out in ST_RD_DATA and with it the input; once the last total is in
// the output register, the input side is free again.
// ---------------------------------------------------------------------------
module tipping_bucket_pulse_counter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tbpc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tbpc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [tbpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbpc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Configuration registers.
   logic [tbpc_pkg::VOLUME_W-1:0] vol_ff;
   logic [tbpc_pkg::WINDOW_W-1:0] lockout_ff;

   // Shared window counter and per-channel flags.  A total whose valid bit is
   // clear reads as zero, so reset and the clear op need no write to the RAM.
   logic [tbpc_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [tbpc_pkg::CHANNELS-1:0] lock_ff, lock_in;
   logic [tbpc_pkg::CHANNELS-1:0] valid_ff, valid_in;

   // Sequencer.
   tbpc_pkg::state_type state_ff, state_in;
   logic [tbpc_pkg::CH_AW-1:0]  tip_ch_ff, tip_ch_in;
   logic [tbpc_pkg::CHAN_W-1:0] idx_ff, idx_in;
   logic                        clr_ff, clr_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   tbpc_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // Totals RAM ports.
   logic                          ram_we;
   logic [tbpc_pkg::CH_AW-1:0]    ram_waddr;
   logic [tbpc_pkg::TOTAL_W-1:0]  ram_wdata;
   logic [tbpc_pkg::CH_AW-1:0]    ram_raddr;
   logic [tbpc_pkg::TOTAL_W-1:0]  ram_rdata;

   logic                          req_fire;
   logic [tbpc_pkg::CH_AW-1:0]    req_ch;
   logic                          req_ch_ok;
   logic [tbpc_pkg::WINDOW_W-1:0] window_inc;
   logic [tbpc_pkg::TOTAL_W-1:0]  tip_base;
   logic [tbpc_pkg::TOTAL_W:0]    tip_sum;
   logic [tbpc_pkg::CH_AW-1:0]    rd_ch;
   logic [tbpc_pkg::TOTAL_W-1:0]  rd_total;
   logic                          rd_last;
   logic                          slot_free;

   tbpc_ram #(
      .WIDTH(tbpc_pkg::TOTAL_W),
      .DEPTH(tbpc_pkg::CHANNELS)
   ) u_totals (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == tbpc_pkg::ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign req_ch = tbpc_pkg::CH_AW'(req_data.channel);
   assign req_ch_ok = ({29'd0, req_data.channel} < 32'(tbpc_pkg::CHANNELS));

   assign window_inc = window_ff + tbpc_pkg::WINDOW_W'(1);

   // Read-modify-write of a tip: the RAM word arrives in ST_TIP.
   assign tip_base = valid_ff[tip_ch_ff] ? ram_rdata : '0;
   assign tip_sum = {1'b0, tip_base}
                  + {{(tbpc_pkg::TOTAL_W + 1 - tbpc_pkg::VOLUME_W){1'b0}}, vol_ff};

   // Read-out: RAM data for idx_ff is present in ST_RD_DATA.
   assign rd_ch = tbpc_pkg::CH_AW'(idx_ff);
   assign rd_total = valid_ff[rd_ch] ? ram_rdata : '0;
   assign rd_last = (idx_ff == tbpc_pkg::CHAN_W'(tbpc_pkg::REPORT_COUNT - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      tip_ch_in = tip_ch_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      window_in = window_ff;
      lock_in = lock_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      ram_we = 1'b0;
      ram_waddr = tip_ch_ff;
      ram_wdata = tip_sum[tbpc_pkg::TOTAL_W] ? '1 : tip_sum[tbpc_pkg::TOTAL_W-1:0];
      ram_raddr = req_ch;

      case (state_ff)
         tbpc_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  tbpc_pkg::OP_TIP: begin
                     if (req_ch_ok) begin
                        // The flag is set whether or not the tip counts.
                        lock_in[req_ch] = 1'b1;
                        tip_ch_in = req_ch;
                        if (!lock_ff[req_ch]) begin
                           state_in = tbpc_pkg::ST_TIP;
                        end
                     end
                  end
                  tbpc_pkg::OP_TICK: begin
                     if (window_inc >= lockout_ff) begin
                        window_in = '0;
                        lock_in = '0;
                     end else begin
                        window_in = window_inc;
                     end
                  end
                  tbpc_pkg::OP_READ: begin
                     idx_in = '0;
                     clr_in = req_data.clear_after;
                     state_in = tbpc_pkg::ST_RD_ADDR;
                  end
                  tbpc_pkg::OP_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tbpc_pkg::ST_TIP: begin
            ram_we = 1'b1;
            valid_in[tip_ch_ff] = 1'b1;
            state_in = tbpc_pkg::ST_IDLE;
         end
         tbpc_pkg::ST_RD_ADDR: begin
            ram_raddr = rd_ch;
            state_in = tbpc_pkg::ST_RD_DATA;
         end
         tbpc_pkg::ST_RD_DATA: begin
            // Hold the address while the output stalls; once the word is
            // loaded, the next channel's address goes out in the same cycle.
            ram_raddr = rd_ch;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_channel = idx_ff;
               rsp_data_in.total = rd_total;
               rsp_data_in.last = rd_last;
               if (clr_ff) begin
                  valid_in[rd_ch] = 1'b0;
               end
               if (rd_last) begin
                  state_in = tbpc_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + tbpc_pkg::CHAN_W'(1);
                  ram_raddr = tbpc_pkg::CH_AW'(idx_in);
               end
            end
         end
         default: begin
            state_in = tbpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         lock_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         clr_ff <= 1'b0;
         tip_ch_ff <= '0;
      end else begin
         window_ff <= window_in;
         lock_ff <= lock_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
         clr_ff <= clr_in;
         tip_ch_ff <= tip_ch_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes; a zero value or an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= tbpc_pkg::VOLUME_RESET;
         lockout_ff <= tbpc_pkg::LOCKOUT_RESET;
      end else if (csr_we) begin
         if (csr_index == tbpc_pkg::REG_VOLUME) begin
            if (csr_wdata != '0) begin
               vol_ff <= csr_wdata;
            end
         end else if (csr_index == tbpc_pkg::REG_LOCKOUT) begin
            if (csr_wdata[tbpc_pkg::WINDOW_W-1:0] != '0) begin
               lockout_ff <= csr_wdata[tbpc_pkg::WINDOW_W-1:0];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### tb/tb_tipping_bucket_pulse_counter_core.sv
// ---------------------------------------------------------------------------
// tb_tipping_bucket_pulse_counter_core: self-checking bench of the tip counter
// Drives tip, tick, read and clear words into the core and predicts every
// read-out total with a cycle-free model of the counter bank. Covers the
// lockout window, register writes, large volumes, back-pressure and a random
// mix of words under three idling settings.
// ---------------------------------------------------------------------------
module tb_tipping_bucket_pulse_counter_core;

   // Index values that decode to no register; writes to them must be dropped.
   localparam logic [tbpc_pkg::CSR_IDX_W-1:0] REG_SPARE_A = tbpc_pkg::CSR_IDX_W'(2);
   localparam logic [tbpc_pkg::CSR_IDX_W-1:0] REG_SPARE_B = tbpc_pkg::CSR_IDX_W'(3);

   // Quiet time after the last owed total; plenty for the core to finish any
   // tip or tick, words that give no result.
   localparam int SETTLE_CYCLES = 20;
   // Far above what some four hundred words need, even if every word were a
   // read and the receiver idled most of the time.
   localparam int CYCLE_LIMIT = 200_000;
   // Tips at the largest volume; each adds almost 2^32 to the total.
   localparam int LARGE_TIPS = 8;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   tbpc_pkg::req_type             req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   tbpc_pkg::rsp_type             rsp_data;
   logic                          csr_we = 1'b0;
   logic [tbpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tbpc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tipping_bucket_pulse_counter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow copy of the counter bank. It is updated at the edge where a word
   // is accepted, which is safe because the core handles words strictly in
   // order and a read-out always reflects every word taken before it.
   // -------------------------------------------------------------------------
   logic [tbpc_pkg::TOTAL_W-1:0]  shadow_total [tbpc_pkg::CHANNELS];
   logic                          shadow_locked [tbpc_pkg::CHANNELS];
   logic [tbpc_pkg::WINDOW_W-1:0] shadow_window = '0;
   logic [tbpc_pkg::VOLUME_W-1:0] shadow_volume = tbpc_pkg::VOLUME_RESET;
   logic [tbpc_pkg::WINDOW_W-1:0] shadow_lockout = tbpc_pkg::LOCKOUT_RESET;

   // Totals the core still owes us, oldest first.
   tbpc_pkg::rsp_type expected_totals[$];

   int mismatch_count = 0;
   int words_sent = 0;
   int totals_checked = 0;
   int cycle_count = 0;

   // Idling of each side, in percent of cycles.
   int send_idle_pct = 25;
   int recv_idle_pct = 81;
   // A test asks for a long receiver stall here; the receiver counts it down.
   int stall_request = 0;

   initial begin
      for (int i = 0; i < tbpc_pkg::CHANNELS; i++) begin
         shadow_total[i] = '0;
         shadow_locked[i] = 1'b0;
      end
   end

   function automatic void zero_shadow_totals();
      for (int i = 0; i < tbpc_pkg::CHANNELS; i++)
         shadow_total[i] = '0;
   endfunction

   // Apply one accepted word to the shadow bank and queue any read-out totals.
   function automatic void track_word(input tbpc_pkg::req_type w);
      logic [tbpc_pkg::TOTAL_W:0] sum;
      tbpc_pkg::rsp_type          item;
      case (w.opcode)
         tbpc_pkg::OP_TIP: begin
            if (int'(w.channel) < tbpc_pkg::CHANNELS) begin
               // A locked channel ignores the tip but stays locked.
               if (!shadow_locked[w.channel]) begin
                  sum = {1'b0, shadow_total[w.channel]} + {17'd0, shadow_volume};
                  shadow_total[w.channel] = sum[tbpc_pkg::TOTAL_W]
                                          ? {tbpc_pkg::TOTAL_W{1'b1}}
                                          : sum[tbpc_pkg::TOTAL_W-1:0];
               end
               shadow_locked[w.channel] = 1'b1;
            end
         end
         tbpc_pkg::OP_TICK: begin
            shadow_window = shadow_window + 1'b1;
            // Greater-or-equal, so a window already past a shortened lockout
            // ends on the very next tick.
            if (shadow_window >= shadow_lockout) begin
               for (int i = 0; i < tbpc_pkg::CHANNELS; i++)
                  shadow_locked[i] = 1'b0;
               shadow_window = '0;
            end
         end
         tbpc_pkg::OP_READ: begin
            for (int i = 0; i < tbpc_pkg::REPORT_COUNT; i++) begin
               item.out_channel = tbpc_pkg::CHAN_W'(i);
               item.total = shadow_total[i];
               item.last = (i == tbpc_pkg::REPORT_COUNT - 1);
               expected_totals.push_back(item);
            end
            if (w.clear_after)
               zero_shadow_totals();
         end
         default: zero_shadow_totals();
      endcase
   endfunction

   function automatic tbpc_pkg::req_type make_word(input logic [1:0] op, input int ch,
                                                   input logic clr);
      tbpc_pkg::req_type w;
      w.opcode = op;
      w.channel = tbpc_pkg::CHAN_W'(ch);
      w.clear_after = clr;
      return w;
   endfunction

   // Hand one word to the core. Valid is left high on return so that a word
   // sent straight after needs no second assignment in the same time step;
   // every wait in the tests goes through settle_core, which lowers it.
   task automatic send_word(input tbpc_pkg::req_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      track_word(w);
      words_sent++;
   endtask

   // Stop sending, wait for every owed total, then give the core time to
   // finish any tip or tick that produces no result.
   task automatic settle_core();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_totals.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the core is idle.
   task automatic write_reg(input logic [tbpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tbpc_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      // A zero value leaves the register as it was; unknown indexes do nothing.
      if (idx == tbpc_pkg::REG_VOLUME && data != '0)
         shadow_volume = data;
      else if (idx == tbpc_pkg::REG_LOCKOUT && data[tbpc_pkg::WINDOW_W-1:0] != '0)
         shadow_lockout = data[tbpc_pkg::WINDOW_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: compare each accepted word with the oldest expectation and
   // pick the next value of rsp_ready, honoring any long stall requested.
   // -------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      tbpc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         totals_checked++;
         if (expected_totals.size() == 0) begin
            $error("unexpected result word: out_channel %0d total %h last %0b",
                   rsp_data.out_channel, rsp_data.total, rsp_data.last);
            mismatch_count++;
         end else begin
            want = expected_totals.pop_front();
            if (rsp_data.out_channel !== want.out_channel) begin
               $error("out_channel: expected %0d, got %0d",
                      want.out_channel, rsp_data.out_channel);
               mismatch_count++;
            end
            if (rsp_data.total !== want.total) begin
               $error("total: expected %h, got %h", want.total, rsp_data.total);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d totals still owed",
                  cycle_count, expected_totals.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Right after reset every total must read as zero.
   task automatic test_reset_readout();
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      settle_core();
   endtask

   // Tips count once per lockout window; reads may clear; clear zeroes all.
   task automatic test_tip_lockout();
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd2);
      write_reg(tbpc_pkg::REG_VOLUME, 32'h0003_0000);
      send_word(make_word(tbpc_pkg::OP_TIP, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 7, 1'b1));
      // Second tip on channel 0 in the same window is swallowed.
      send_word(make_word(tbpc_pkg::OP_TIP, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 0, 1'b0));
      // This tick reaches the window length and unlocks every channel.
      send_word(make_word(tbpc_pkg::OP_TICK, 5, 1'b1));
      send_word(make_word(tbpc_pkg::OP_TIP, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      send_word(make_word(tbpc_pkg::OP_READ, 3, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 3, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 4, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      // A clear leaves the lock flags alone: channel 3 must stay locked.
      send_word(make_word(tbpc_pkg::OP_CLEAR, 6, 1'b1));
      send_word(make_word(tbpc_pkg::OP_TIP, 3, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      settle_core();
   endtask

   // Zero writes and unknown indexes are dropped; extreme values stick.
   task automatic test_registers();
      write_reg(tbpc_pkg::REG_VOLUME, 32'd0);
      // Only the low 16 bits reach the lockout register, and they are zero.
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'h0001_0000);
      write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_B, 32'h0000_0001);
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 1, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      settle_core();
      write_reg(tbpc_pkg::REG_VOLUME, 32'd1);
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd65535);
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 2, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 6, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      settle_core();
   endtask

   // Lowering the lockout below the running window ends it on the next tick.
   task automatic test_lockout_shortened();
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd100);
      write_reg(tbpc_pkg::REG_VOLUME, 32'h0000_8000);
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 2, 1'b0));
      for (int i = 0; i < 10; i++)
         send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 2, 1'b0));
      settle_core();
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd3);
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 2, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      settle_core();
   endtask

   // With a one-tick window and the largest volume, channel 5 climbs to about
   // 2^35 in its 48-bit total.
   task automatic test_large_volume();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(tbpc_pkg::REG_VOLUME, 32'hFFFF_FFFF);
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd1);
      send_word(make_word(tbpc_pkg::OP_CLEAR, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      for (int i = 0; i < LARGE_TIPS; i++) begin
         send_word(make_word(tbpc_pkg::OP_TIP, 5, 1'b0));
         send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      end
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      settle_core();
   endtask

   // The receiver stalls for a long stretch while reads keep coming, so the
   // output register fills and the core must hold off its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 30;
      write_reg(tbpc_pkg::REG_VOLUME, 32'h0001_2345);
      write_reg(tbpc_pkg::REG_LOCKOUT, 32'd2);
      stall_request = 400;
      send_word(make_word(tbpc_pkg::OP_TIP, 4, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 1, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TICK, 0, 1'b0));
      send_word(make_word(tbpc_pkg::OP_TIP, 4, 1'b0));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b1));
      send_word(make_word(tbpc_pkg::OP_READ, 0, 1'b0));
      settle_core();
   endtask

   // Random mix, mostly tips and ticks so that totals build up between reads.
   function automatic tbpc_pkg::req_type random_word();
      int pick;
      logic [1:0] op;
      pick = $urandom_range(99);
      if (pick < 45)
         op = tbpc_pkg::OP_TIP;
      else if (pick < 78)
         op = tbpc_pkg::OP_TICK;
      else if (pick < 92)
         op = tbpc_pkg::OP_READ;
      else
         op = tbpc_pkg::OP_CLEAR;
      return make_word(op, $urandom_range(tbpc_pkg::CHANNELS - 1),
                       1'($urandom_range(1)));
   endfunction

   task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                    input int count);
      logic [tbpc_pkg::CSR_DATA_W-1:0] volume;
      case ($urandom_range(3))
         0: volume = 32'd1;
         1: volume = 32'hFFFF_FFFF;
         2: volume = tbpc_pkg::VOLUME_RESET;
         default: volume = $urandom;
      endcase
      write_reg(tbpc_pkg::REG_VOLUME, volume);
      write_reg(tbpc_pkg::REG_LOCKOUT, $urandom_range(6, 1));
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int i = 0; i < count; i++)
         send_word(random_word());
      // The sender pauses here until the core has delivered every total.
      settle_core();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_readout();
      test_tip_lockout();
      test_registers();
      test_lockout_shortened();
      test_backpressure();
      test_large_volume();
      test_random_phase(25, 81, 55);
      test_random_phase(25, 81, 55);
      test_random_phase(81, 25, 55);
      test_random_phase(81, 25, 55);
      test_random_phase(0, 0, 55);
      test_random_phase(0, 0, 55);

      $display("Sent %0d words (tips, ticks, reads, clears) and checked %0d totals,",
               words_sent, totals_checked);
      $display("including lockout windows, register edge cases, large volumes and stalls.");
      if (mismatch_count == 0 && expected_totals.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
